// ===== rtl/dss_pkg.sv =====
// shared types, constants and angle table of the slope stencil
package dss_pkg;

  localparam int MAX_COLS     = 2048;
  localparam int HEIGHT_BITS  = 24;
  localparam int COL_BITS     = $clog2(MAX_COLS);
  localparam int ENTRY_W      = HEIGHT_BITS + 1;
  localparam int SPAN_W       = 24;
  localparam int PROD_W       = HEIGHT_BITS + SPAN_W;
  localparam int SLOPE_W      = 15;
  localparam int SLOPE_MAX    = 23040;
  localparam int CORDIC_STEPS = 20;
  localparam int SQRT_STEPS   = 32;
  localparam int CNT_W        = 5;
  localparam int CD_W         = 36;
  localparam int Z_W          = 25;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 24;

  typedef logic signed [HEIGHT_BITS-1:0] height_t;
  typedef logic [SLOPE_W-1:0]            slope_t;
  typedef logic [COL_BITS-1:0]           col_t;
  typedef logic [ENTRY_W-1:0]            entry_t;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_COLS = 3'd0,
    REG_GRID_ROWS = 3'd1,
    REG_INV_X     = 3'd2,
    REG_INV_Y     = 3'd3
  } cfg_reg_t;

  // atan(2^-i) in degrees, Q.16, rounded
  function automatic logic signed [Z_W-1:0] atan_q16(input logic [CNT_W-1:0] i);
    logic signed [Z_W-1:0] v;
    case (i)
      5'd0:  v = 25'sd2949120;
      5'd1:  v = 25'sd1740967;
      5'd2:  v = 25'sd919879;
      5'd3:  v = 25'sd466945;
      5'd4:  v = 25'sd234379;
      5'd5:  v = 25'sd117304;
      5'd6:  v = 25'sd58666;
      5'd7:  v = 25'sd29335;
      5'd8:  v = 25'sd14668;
      5'd9:  v = 25'sd7334;
      5'd10: v = 25'sd3667;
      5'd11: v = 25'sd1833;
      5'd12: v = 25'sd917;
      5'd13: v = 25'sd458;
      5'd14: v = 25'sd229;
      5'd15: v = 25'sd115;
      5'd16: v = 25'sd57;
      5'd17: v = 25'sd29;
      5'd18: v = 25'sd14;
      5'd19: v = 25'sd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/dss_if.sv =====
// valid/ready channels for elevation samples and slope results
interface dss_in_if;
  logic             valid;
  logic             ready;
  dss_pkg::height_t height;
  logic             height_void;
  logic             flush;

  modport source (output valid, height, height_void, flush, input ready);
  modport sink   (input valid, height, height_void, flush, output ready);
endinterface

interface dss_out_if;
  logic            valid;
  logic            ready;
  dss_pkg::slope_t slope_deg;
  logic            slope_valid;
  logic            last_cell;
  dss_pkg::slope_t min_slope;
  dss_pkg::slope_t max_slope;

  modport source (output valid, slope_deg, slope_valid, last_cell, min_slope, max_slope,
                  input ready);
  modport sink   (input valid, slope_deg, slope_valid, last_cell, min_slope, max_slope,
                  output ready);
endinterface

// ===== rtl/dem_slope_stencil.sv =====
// top level: line-buffered cross-stencil slope with sqrt and cordic units
//
//  channel | dir | beat contents
//  in_s    | in  | height, height_void, flush
//  out_s   | out | slope_deg, slope_valid, last_cell, min_slope, max_slope
//  cfg_*   | in  | write enable, register index, write data
//
// one item at a time: an early flush is dropped, a first-row sample is only written,
// an invalid cell is emitted after the stencil reads, and a valid cell is normalized
// by a shift s (0..17) and then runs the 32-step square root and 20-step cordic; a
// zero gradient skips the cordic; emit waits while a held output beat is not taken.
// rst_n is synchronous; the line buffers are not cleared.
// a finished result waits in the output register while the next sample is taken.
module dem_slope_stencil (
  input  logic                             clk,
  input  logic                             rst_n,
  dss_in_if.sink                           in_s,
  dss_out_if.source                        out_s,
  input  logic                             cfg_we,
  input  logic [dss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dss_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import dss_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_WRITE, ST_READ, ST_CHECK, ST_MUL, ST_NORM, ST_SQA, ST_SQB,
    ST_SQRT, ST_PRE, ST_CORDIC, ST_ROUND, ST_EMIT
  } state_t;

  state_t state_r;

  // configuration
  logic [11:0]        grid_cols_r;
  logic [15:0]        grid_rows_r;
  logic [SPAN_W-1:0]  inv_x_r, inv_y_r;

  // raster position and statistics
  col_t               col_count_r;
  logic [15:0]        row_count_r;
  logic               cur_sel_r;
  slope_t             run_min_r, run_max_r;
  logic               seen_r;

  // item registers
  col_t               c_r;
  entry_t             entry_r;
  logic               drain_r;
  logic [1:0]         step_r;
  entry_t             cen_r, so_r, w_r, e_r;
  logic               valid_r;
  logic [HEIGHT_BITS-1:0] dx_r, dy_r;
  logic [PROD_W-1:0]  gx_r, gy_r;
  logic [16:0]        unit_r;
  logic [63:0]        sqx_r, n_r, res_r, bit_r;
  logic [CNT_W-1:0]   cnt_r;
  logic signed [CD_W-1:0] x_r, y_r;
  logic signed [Z_W-1:0]  z_r;
  slope_t             sl_r;

  // output register
  logic               out_valid_r;
  slope_t             out_slope_r, out_min_r, out_max_r;
  logic               out_sv_r, out_last_r;

  // effective geometry
  logic [COL_BITS:0]  cols_w;
  logic [15:0]        rows_w;
  logic [31:0]        gc32;
  assign gc32 = 32'(grid_cols_r);
  always_comb begin
    if (grid_cols_r == '0) begin
      cols_w = (COL_BITS+1)'(1);
    end else if (gc32 > 32'(MAX_COLS)) begin
      cols_w = (COL_BITS+1)'(MAX_COLS);
    end else begin
      cols_w = (COL_BITS+1)'(grid_cols_r);
    end
  end
  assign rows_w = (grid_rows_r == '0) ? 16'd1 : grid_rows_r;

  // accept decode
  logic in_fire, drain_now, ignore_now;
  col_t c_now;
  logic [COL_BITS:0] cols_m1;
  assign in_s.ready = (state_r == ST_IDLE);
  assign in_fire    = in_s.valid && in_s.ready;
  assign drain_now  = (row_count_r >= rows_w);
  assign ignore_now = !drain_now && in_s.flush;
  assign cols_m1    = cols_w - 1'b1;
  assign c_now      = ({1'b0, col_count_r} >= cols_w) ? cols_m1[COL_BITS-1:0] : col_count_r;

  logic [COL_BITS:0] c_inc;
  logic end_row;
  assign c_inc   = {1'b0, c_r} + 1'b1;
  assign end_row = (c_inc >= cols_w);

  // line buffer banks, cur_sel_r picks the bank holding the row above
  logic   ram_we, we0, we1;
  col_t   cur_raddr, ra0, ra1;
  entry_t rd0, rd1, cur_rdata, oth_rdata;
  always_comb begin
    case (step_r)
      2'd1:    cur_raddr = (c_r == '0) ? c_r : c_r - 1'b1;
      2'd2:    cur_raddr = end_row ? c_r : c_inc[COL_BITS-1:0];
      default: cur_raddr = c_r;
    endcase
  end
  assign ram_we    = (state_r == ST_WRITE) ||
                     (state_r == ST_READ && step_r == 2'd1 && !drain_r);
  assign we0       = ram_we && cur_sel_r;
  assign we1       = ram_we && !cur_sel_r;
  assign ra0       = cur_sel_r ? c_r : cur_raddr;
  assign ra1       = cur_sel_r ? cur_raddr : c_r;
  assign cur_rdata = cur_sel_r ? rd1 : rd0;
  assign oth_rdata = cur_sel_r ? rd0 : rd1;

  dss_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_COLS)) u_bank0 (
    .clk(clk), .we(we0), .waddr(c_r), .wdata(entry_r), .raddr(ra0), .rdata(rd0)
  );
  dss_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_COLS)) u_bank1 (
    .clk(clk), .we(we1), .waddr(c_r), .wdata(entry_r), .raddr(ra1), .rdata(rd1)
  );

  // stencil check and differences
  entry_t so_sel, no_sel;
  logic   valid_now;
  logic signed [HEIGHT_BITS:0] dwe, dsn;
  logic signed [HEIGHT_BITS:0] awe, asn;
  assign so_sel    = (row_count_r >= 16'd2) ? so_r : cen_r;
  assign no_sel    = drain_r ? cen_r : entry_r;
  assign valid_now = !cen_r[HEIGHT_BITS] && !w_r[HEIGHT_BITS] && !e_r[HEIGHT_BITS] &&
                     !so_sel[HEIGHT_BITS] && !no_sel[HEIGHT_BITS];
  assign dwe = $signed({w_r[HEIGHT_BITS-1], w_r[HEIGHT_BITS-1:0]}) -
               $signed({e_r[HEIGHT_BITS-1], e_r[HEIGHT_BITS-1:0]});
  assign dsn = $signed({so_sel[HEIGHT_BITS-1], so_sel[HEIGHT_BITS-1:0]}) -
               $signed({no_sel[HEIGHT_BITS-1], no_sel[HEIGHT_BITS-1:0]});
  assign awe = dwe[HEIGHT_BITS] ? -dwe : dwe;
  assign asn = dsn[HEIGHT_BITS] ? -dsn : dsn;

  // square root step
  logic [63:0] trial;
  assign trial = res_r + bit_r;

  // cordic step
  logic signed [CD_W-1:0] xs, ys;
  assign xs = x_r >>> cnt_r;
  assign ys = y_r >>> cnt_r;

  // rounding
  logic signed [Z_W-1:0] zr;
  assign zr = (z_r + Z_W'(128)) >>> 8;

  // output slot and statistics
  logic   emit_fire;
  slope_t nmin, nmax;
  assign emit_fire = (state_r == ST_EMIT) && (!out_valid_r || out_s.ready);
  always_comb begin
    nmin = run_min_r;
    nmax = run_max_r;
    if (valid_r) begin
      if (!seen_r) begin
        nmin = sl_r;
        nmax = sl_r;
      end else begin
        if (sl_r < run_min_r) nmin = sl_r;
        if (sl_r > run_max_r) nmax = sl_r;
      end
    end
  end

  logic advance;
  assign advance = (state_r == ST_WRITE) || emit_fire;

  // sequencer, counters, config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      grid_cols_r <= 12'd2048;
      grid_rows_r <= 16'd1;
      inv_x_r     <= 24'h010000;
      inv_y_r     <= 24'h010000;
      col_count_r <= '0;
      row_count_r <= '0;
      cur_sel_r   <= 1'b0;
      run_min_r   <= '0;
      run_max_r   <= '0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
      cnt_r       <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_fire && !ignore_now) begin
            c_r     <= c_now;
            entry_r <= {in_s.height_void, in_s.height};
            drain_r <= drain_now;
            step_r  <= '0;
            state_r <= (row_count_r == '0) ? ST_WRITE : ST_READ;
          end
        end
        ST_WRITE: begin
          state_r <= ST_IDLE;
        end
        ST_READ: begin
          step_r <= step_r + 1'b1;
          case (step_r)
            2'd1: begin
              cen_r <= cur_rdata;
              so_r  <= oth_rdata;
            end
            2'd2: w_r <= cur_rdata;
            2'd3: begin
              e_r     <= cur_rdata;
              state_r <= ST_CHECK;
            end
            default: ;
          endcase
        end
        ST_CHECK: begin
          valid_r <= valid_now;
          dx_r    <= awe[HEIGHT_BITS-1:0];
          dy_r    <= asn[HEIGHT_BITS-1:0];
          sl_r    <= '0;
          state_r <= valid_now ? ST_MUL : ST_EMIT;
        end
        ST_MUL: begin
          gx_r    <= PROD_W'(dx_r) * PROD_W'(inv_x_r);
          gy_r    <= PROD_W'(dy_r) * PROD_W'(inv_y_r);
          unit_r  <= 17'h10000;
          state_r <= ST_NORM;
        end
        ST_NORM: begin
          if ((|gx_r[PROD_W-1:31]) || (|gy_r[PROD_W-1:31])) begin
            gx_r   <= gx_r >> 1;
            gy_r   <= gy_r >> 1;
            unit_r <= unit_r >> 1;
          end else begin
            state_r <= ST_SQA;
          end
        end
        ST_SQA: begin
          sqx_r   <= 64'(gx_r[30:0]) * 64'(gx_r[30:0]);
          state_r <= ST_SQB;
        end
        ST_SQB: begin
          n_r     <= sqx_r + 64'(gy_r[30:0]) * 64'(gy_r[30:0]);
          res_r   <= '0;
          bit_r   <= 64'h4000_0000_0000_0000;
          cnt_r   <= '0;
          state_r <= ST_SQRT;
        end
        ST_SQRT: begin
          if (n_r >= trial) begin
            n_r   <= n_r - trial;
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(SQRT_STEPS - 1)) begin
            state_r <= ST_PRE;
          end
        end
        ST_PRE: begin
          if (res_r[31:0] == '0) begin
            sl_r    <= '0;
            state_r <= ST_EMIT;
          end else if (unit_r == '0) begin
            sl_r    <= SLOPE_W'(SLOPE_MAX);
            state_r <= ST_EMIT;
          end else begin
            x_r     <= CD_W'(unit_r);
            y_r     <= CD_W'(res_r[31:0]);
            z_r     <= '0;
            cnt_r   <= '0;
            state_r <= ST_CORDIC;
          end
        end
        ST_CORDIC: begin
          if (y_r > 0) begin
            x_r <= x_r + ys;
            y_r <= y_r - xs;
            z_r <= z_r + atan_q16(cnt_r);
          end else begin
            x_r <= x_r - ys;
            y_r <= y_r + xs;
            z_r <= z_r - atan_q16(cnt_r);
          end
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(CORDIC_STEPS - 1)) begin
            state_r <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          if (z_r <= 0) begin
            sl_r <= '0;
          end else if (zr > Z_W'(SLOPE_MAX)) begin
            sl_r <= SLOPE_W'(SLOPE_MAX);
          end else begin
            sl_r <= zr[SLOPE_W-1:0];
          end
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_fire) begin
            out_slope_r <= sl_r;
            out_sv_r    <= valid_r;
            out_last_r  <= drain_r && end_row;
            out_min_r   <= nmin;
            out_max_r   <= nmax;
            // statistics carry on unless the grid ends here
            if (!(drain_r && end_row)) begin
              run_min_r <= nmin;
              run_max_r <= nmax;
              seen_r    <= seen_r || valid_r;
            end
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase

      // output register handshake
      if (emit_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_s.ready) begin
        out_valid_r <= 1'b0;
      end

      // raster position at the end of an item
      if (advance) begin
        if (!end_row) begin
          col_count_r <= c_inc[COL_BITS-1:0];
        end else if (drain_r) begin
          col_count_r <= '0;
          row_count_r <= '0;
          run_min_r   <= '0;
          run_max_r   <= '0;
          seen_r      <= 1'b0;
        end else begin
          col_count_r <= '0;
          row_count_r <= row_count_r + 1'b1;
          cur_sel_r   <= !cur_sel_r;
        end
      end

      // configuration writes, geometry restarts the grid
      if (cfg_we) begin
        case (cfg_index)
          REG_GRID_COLS, REG_GRID_ROWS: begin
            if (cfg_index == REG_GRID_COLS) begin
              grid_cols_r <= cfg_wdata[11:0];
            end else begin
              grid_rows_r <= cfg_wdata[15:0];
            end
            col_count_r <= '0;
            row_count_r <= '0;
            run_min_r   <= '0;
            run_max_r   <= '0;
            seen_r      <= 1'b0;
          end
          REG_INV_X: inv_x_r <= cfg_wdata;
          REG_INV_Y: inv_y_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  assign out_s.valid       = out_valid_r;
  assign out_s.slope_deg   = out_slope_r;
  assign out_s.slope_valid = out_sv_r;
  assign out_s.last_cell   = out_last_r;
  assign out_s.min_slope   = out_min_r;
  assign out_s.max_slope   = out_max_r;

  // a result appears only from the emit step
  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EMIT))
    else $error("result raised outside emit step");

  // a valid slope lies within the running bounds
  a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_sv_r |-> (out_min_r <= out_slope_r) && (out_slope_r <= out_max_r))
    else $error("slope outside running min/max");

  // cordic never runs past its step count
  a_cordic: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CORDIC |-> cnt_r < CNT_W'(CORDIC_STEPS))
    else $error("cordic step count overrun");

endmodule

// ===== rtl/dss_ram.sv =====
// generic single-port-write, registered-read ram
module dss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule
